FILE: src/mru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_pkg
// Shared types and constants of the mixed-radix index unravel block.
// ----------------------------------------------------------------------------
package mru_pkg;

  localparam int IDX_W      = 48;  // flat index width
  localparam int HW_DIMS    = 4;   // coordinate lanes built in hardware
  localparam int CFG_IDX_W  = 3;   // register index width
  localparam int CFG_DATA_W = 13;  // register data width
  localparam int DIM_CNT_W  = 3;   // dimension count register width
  localparam int DIV_STEPS  = 4;   // quotient bits resolved per stage

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_COUNT = 3'd0,
    REG_RADIX_0   = 3'd1,
    REG_RADIX_1   = 3'd2,
    REG_RADIX_2   = 3'd3,
    REG_RADIX_3   = 3'd4
  } cfg_reg_e;

endpackage

FILE: src/mru_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_if
// Channel interfaces: flat index input, coordinate output, register writes.
// ----------------------------------------------------------------------------
interface mru_idx_if #(parameter int W = 48);
  logic         valid;
  logic         ready;
  logic [W-1:0] flat_index;
  modport source (output valid, output flat_index, input ready);
  modport sink   (input valid, input flat_index, output ready);
endinterface

interface mru_crd_if #(parameter int CW = 12);
  logic          valid;
  logic          ready;
  logic [CW-1:0] coord_0;
  logic [CW-1:0] coord_1;
  logic [CW-1:0] coord_2;
  logic [CW-1:0] coord_3;
  logic          out_of_range;
  modport source (output valid, output coord_0, output coord_1, output coord_2,
                  output coord_3, output out_of_range, input ready);
  modport sink   (input valid, input coord_0, input coord_1, input coord_2,
                  input coord_3, input out_of_range, output ready);
endinterface

interface mru_cfg_if #(parameter int IW = 3, parameter int DW = 13);
  logic          valid;
  logic          ready;
  logic [IW-1:0] index;
  logic [DW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/mru_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_cfg
// Configuration registers and the effective divisor of each dimension.
// ----------------------------------------------------------------------------
module mru_cfg #(
  parameter int MAX_DIMS   = 4,
  parameter int RADIX_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  mru_cfg_if.sink cfg_i,
  output logic [mru_pkg::HW_DIMS-1:0][RADIX_BITS:0] divisor_o
);
  import mru_pkg::*;

  logic [DIM_CNT_W-1:0]                 dim_cnt_q;
  logic [HW_DIMS-1:0][CFG_DATA_W-1:0]   radix_q;
  logic [DIM_CNT_W-1:0]                 dims_eff;

  function automatic logic [RADIX_BITS:0] clamp_radix(logic [CFG_DATA_W-1:0] r);
    int unsigned rv;
    int unsigned cap;
    rv  = 32'(r);
    cap = 32'd1 << RADIX_BITS;
    if (rv == 0) begin
      rv = 1;
    end else if (rv > cap) begin
      rv = cap;
    end
    return rv[RADIX_BITS:0];
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_cnt_q <= DIM_CNT_W'(1);
      for (int k = 0; k < HW_DIMS; k++) begin
        radix_q[k] <= CFG_DATA_W'(1);
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DIM_COUNT: dim_cnt_q  <= cfg_i.data[DIM_CNT_W-1:0];
        REG_RADIX_0:   radix_q[0] <= cfg_i.data;
        REG_RADIX_1:   radix_q[1] <= cfg_i.data;
        REG_RADIX_2:   radix_q[2] <= cfg_i.data;
        REG_RADIX_3:   radix_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dims_eff = dim_cnt_q;
    if (dims_eff == '0) begin
      dims_eff = DIM_CNT_W'(1);
    end
    if (32'(dims_eff) > MAX_DIMS) begin
      dims_eff = DIM_CNT_W'(MAX_DIMS);
    end
  end

  // An unused dimension divides by one: coordinate zero, value unchanged.
  always_comb begin
    for (int k = 0; k < HW_DIMS; k++) begin
      if (32'(k) < 32'(dims_eff)) begin
        divisor_o[k] = clamp_radix(radix_q[k]);
      end else begin
        divisor_o[k] = (RADIX_BITS+1)'(1);
      end
    end
  end

endmodule

FILE: src/mru_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_div_stage
// One pipeline stage of restoring long division, DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module mru_div_stage #(
  parameter int RADIX_BITS = 12,
  parameter int DIM        = 0,
  parameter bit DONE       = 1'b0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic [RADIX_BITS-1:0] rem_i,
  input  logic [mru_pkg::IDX_W-1:0] num_i,
  input  logic [mru_pkg::HW_DIMS-1:0][RADIX_BITS-1:0] crd_i,
  input  logic [RADIX_BITS:0] divisor_i,
  output logic valid_o,
  input  logic ready_i,
  output logic [RADIX_BITS-1:0] rem_o,
  output logic [mru_pkg::IDX_W-1:0] num_o,
  output logic [mru_pkg::HW_DIMS-1:0][RADIX_BITS-1:0] crd_o
);
  import mru_pkg::*;

  logic                              valid_q;
  logic [RADIX_BITS-1:0]             rem_d, rem_q;
  logic [IDX_W-1:0]                  num_d, num_q;
  logic [HW_DIMS-1:0][RADIX_BITS-1:0] crd_d, crd_q;

  // The numerator shifts out at the top while quotient bits shift in below,
  // so after a full pass num holds the quotient.
  always_comb begin
    logic [RADIX_BITS:0] t;
    rem_d = rem_i;
    num_d = num_i;
    crd_d = crd_i;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {rem_d, num_d[IDX_W-1]};
      num_d = {num_d[IDX_W-2:0], 1'b0};
      if (t >= divisor_i) begin
        t        = t - divisor_i;
        num_d[0] = 1'b1;
      end
      rem_d = t[RADIX_BITS-1:0];
    end
    if (DONE) begin
      crd_d[DIM] = rem_d;
      rem_d      = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      crd_q <= crd_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign crd_o   = crd_q;

endmodule

FILE: src/mixed_radix_index_unravel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_radix_index_unravel
// Splits a row-major flat index into per-dimension grid coordinates.
// ----------------------------------------------------------------------------
//   Channel  Dir  Carries
//   in_i     in   flat_index, one word per grid point
//   out_o    out  coord_0..coord_3 and out_of_range
//   cfg_i    in   register index and data (dimension count, four radices)
//
// One word enters per cycle unless the output stalls. Each dimension takes
// IDX_W / DIV_STEPS division stages (12 by default), fastest dimension first,
// then one output register.
// Reset returns every configuration register to one and empties the pipeline.
// Each stage holds its word on a stall and refills a bubble ahead of it.
// ----------------------------------------------------------------------------
module mixed_radix_index_unravel #(
  parameter int MAX_DIMS   = 4,
  parameter int RADIX_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  mru_idx_if.sink   in_i,
  mru_crd_if.source out_o,
  mru_cfg_if.sink   cfg_i
);
  import mru_pkg::*;

  localparam int STG_PER_DIM = IDX_W / DIV_STEPS;
  localparam int N_STG       = HW_DIMS * STG_PER_DIM;

  logic [HW_DIMS-1:0][RADIX_BITS:0] divisor;

  // Link n feeds stage n; link N_STG feeds the output register.
  logic [N_STG:0]                                    lnk_valid;
  logic [N_STG:0]                                    lnk_ready;
  logic [N_STG:0][RADIX_BITS-1:0]                    lnk_rem;
  logic [N_STG:0][IDX_W-1:0]                         lnk_num;
  logic [N_STG:0][HW_DIMS-1:0][RADIX_BITS-1:0]       lnk_crd;

  logic                               out_valid_q;
  logic [HW_DIMS-1:0][RADIX_BITS-1:0] out_crd_q;
  logic                               out_oor_q;

  mru_cfg #(
    .MAX_DIMS  (MAX_DIMS),
    .RADIX_BITS(RADIX_BITS)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .divisor_o(divisor)
  );

  assign lnk_valid[0] = in_i.valid;
  assign in_i.ready   = lnk_ready[0];
  assign lnk_rem[0]   = '0;
  assign lnk_num[0]   = in_i.flat_index;
  assign lnk_crd[0]   = '0;

  // The last dimension varies fastest, so it is peeled off first.
  for (genvar n = 0; n < N_STG; n++) begin : g_stage
    localparam int DIM = HW_DIMS - 1 - (n / STG_PER_DIM);
    localparam bit FIN = ((n % STG_PER_DIM) == STG_PER_DIM - 1);
    mru_div_stage #(
      .RADIX_BITS(RADIX_BITS),
      .DIM       (DIM),
      .DONE      (FIN)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (lnk_valid[n]),
      .ready_o  (lnk_ready[n]),
      .rem_i    (lnk_rem[n]),
      .num_i    (lnk_num[n]),
      .crd_i    (lnk_crd[n]),
      .divisor_i(divisor[DIM]),
      .valid_o  (lnk_valid[n+1]),
      .ready_i  (lnk_ready[n+1]),
      .rem_o    (lnk_rem[n+1]),
      .num_o    (lnk_num[n+1]),
      .crd_o    (lnk_crd[n+1])
    );
  end

  // Whatever quotient is left after dimension zero lies beyond the grid.
  assign lnk_ready[N_STG] = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lnk_ready[N_STG]) begin
      out_valid_q <= lnk_valid[N_STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lnk_ready[N_STG] && lnk_valid[N_STG]) begin
      out_crd_q <= lnk_crd[N_STG];
      out_oor_q <= |lnk_num[N_STG];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.coord_0      = out_crd_q[0];
  assign out_o.coord_1      = out_crd_q[1];
  assign out_o.coord_2      = out_crd_q[2];
  assign out_o.coord_3      = out_crd_q[3];
  assign out_o.out_of_range = out_oor_q;

endmodule
